### sv/osnc_pkg.sv
`default_nettype none

package osnc_pkg;

    localparam int COUNTER_WIDTH = 64;
    localparam int FREQ_W        = 30;
    localparam int DUR_W         = 64;
    localparam int NS_W          = 64;
    localparam int PROD_W        = DUR_W + FREQ_W;
    localparam int MUL_STEPS     = FREQ_W;
    localparam int DIV_STEPS     = PROD_W / 2;
    localparam int STEP_W        = $clog2(DIV_STEPS + 1);
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 3;

    localparam logic [FREQ_W-1:0]        FREQ_RESET = FREQ_W'(10000000);
    localparam logic [FREQ_W-1:0]        NS_PER_SEC = FREQ_W'(1000000000);
    localparam logic [COUNTER_WIDTH-1:0] CNT_ONES   = '1;

    localparam logic [ADDR_W-3:0] REG_TICK_FREQ = '0;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ARM  = 2'd1,
        OP_READ = 2'd2,
        OP_ACK  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

`default_nettype wire

### sv/oneshot_timer_ns_compare_core.sv
`default_nettype none

// One-shot timer on a free-running tick counter with a compare register.
// Each transaction gives exactly one result. Tick, acknowledge and disarm go
// from accept straight to the done state, which loads the output register.
// Arm (nonzero duration) and read go through one shared multiply/divide
// datapath. It runs a shift-add multiply over the 94-bit product, then a
// two-bit-per-cycle restoring divider, then the done state loads the output
// register. Only one transaction is in work at a time. A finished result
// waits in the output register while the next one is taken. While that
// register is still held by an output stall, the finishing transaction
// waits in its last cycle. The frequency register (byte address 0) treats
// 0 as 1 Hz and must only be written while the block is idle.
module oneshot_timer_ns_compare_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,

    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [osnc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [osnc_pkg::DATA_W-1:0] pwdata,
    output logic      [osnc_pkg::DATA_W-1:0] prdata,
    output logic                             pready,

    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [1:0]                  i_operation,
    input  wire logic [osnc_pkg::DUR_W-1:0]  i_duration_ns,

    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [osnc_pkg::NS_W-1:0]   o_now_ns,
    output logic                             o_irq_pending,
    output logic                             o_callback_due,
    output logic                             o_is_armed
);
    import osnc_pkg::*;

    t_state                   r_state, n_state;
    logic [FREQ_W-1:0]        r_freq, n_freq;
    logic [COUNTER_WIDTH-1:0] r_cnt, n_cnt;
    logic [COUNTER_WIDTH-1:0] r_cmp, n_cmp;
    logic                     r_armed, n_armed;
    logic                     r_out_valid, n_out_valid;
    t_op                      r_op, n_op;

    logic [PROD_W-1:0]        r_p, n_p;
    logic [DUR_W-1:0]         r_a, n_a;
    logic [FREQ_W-1:0]        r_b, n_b;
    logic [FREQ_W-1:0]        r_d, n_d;
    logic [FREQ_W-1:0]        r_rem, n_rem;
    logic [STEP_W-1:0]        r_step, n_step;
    logic [NS_W-1:0]          r_now, n_now;
    logic                     r_due, n_due;
    logic [NS_W-1:0]          r_o_now, n_o_now;
    logic                     r_o_irq, n_o_irq;
    logic                     r_o_due, n_o_due;
    logic                     r_o_armed, n_o_armed;

    logic                     in_take;
    logic                     out_free;
    logic                     cfg_wr;
    logic [FREQ_W-1:0]        freq_eff;
    logic [FREQ_W:0]          rem1, rem2;
    logic [FREQ_W-1:0]        rem1s, rem2s;
    logic                     q1, q2;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[ADDR_W-1:2] == REG_TICK_FREQ) ? DATA_W'(r_freq) : '0;
    assign freq_eff = (r_freq == '0) ? FREQ_W'(1) : r_freq;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // two restoring divide steps per cycle
    assign rem1  = {r_rem, r_p[PROD_W-1]};
    assign q1    = (rem1 >= {1'b0, r_d});
    assign rem1s = q1 ? FREQ_W'(rem1 - {1'b0, r_d}) : rem1[FREQ_W-1:0];
    assign rem2  = {rem1s, r_p[PROD_W-2]};
    assign q2    = (rem2 >= {1'b0, r_d});
    assign rem2s = q2 ? FREQ_W'(rem2 - {1'b0, r_d}) : rem2[FREQ_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_freq      = r_freq;
        n_cnt       = r_cnt;
        n_cmp       = r_cmp;
        n_armed     = r_armed;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_p         = r_p;
        n_a         = r_a;
        n_b         = r_b;
        n_d         = r_d;
        n_rem       = r_rem;
        n_step      = r_step;
        n_now       = r_now;
        n_due       = r_due;
        n_o_now     = r_o_now;
        n_o_irq     = r_o_irq;
        n_o_due     = r_o_due;
        n_o_armed   = r_o_armed;

        if (cfg_wr && paddr[ADDR_W-1:2] == REG_TICK_FREQ) begin
            n_freq = pwdata[FREQ_W-1:0];
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_op    = t_op'(i_operation);
                    n_now   = '0;
                    n_due   = 1'b0;
                    n_p     = '0;
                    n_step  = '0;
                    n_state = S_DONE;
                    case (t_op'(i_operation))
                        OP_TICK: begin
                            n_cnt = r_cnt + COUNTER_WIDTH'(1);
                        end
                        OP_ARM: begin
                            if (i_duration_ns == '0) begin
                                n_cmp   = CNT_ONES;
                                n_armed = 1'b0;
                            end else begin
                                n_a     = i_duration_ns;
                                n_b     = freq_eff;
                                n_d     = NS_PER_SEC;
                                n_state = S_MUL;
                            end
                        end
                        OP_READ: begin
                            n_a     = DUR_W'(r_cnt);
                            n_b     = NS_PER_SEC;
                            n_d     = freq_eff;
                            n_state = S_MUL;
                        end
                        OP_ACK: begin
                            n_due   = r_armed;
                            n_cmp   = CNT_ONES;
                            n_armed = 1'b0;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_p    = {r_p[PROD_W-2:0], 1'b0}
                       + (r_b[FREQ_W-1] ? PROD_W'(r_a) : PROD_W'(0));
                n_b    = {r_b[FREQ_W-2:0], 1'b0};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_step  = '0;
                    n_rem   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_p    = {r_p[PROD_W-3:0], q1, q2};
                n_rem  = rem2s;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                    if (r_op == OP_ARM) begin
                        n_cmp   = r_cnt + n_p[COUNTER_WIDTH-1:0];
                        n_armed = 1'b1;
                    end else begin
                        n_now = n_p[NS_W-1:0];
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_now     = r_now;
                    n_o_irq     = (r_cnt >= r_cmp);
                    n_o_due     = r_due;
                    n_o_armed   = r_armed;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_freq      <= FREQ_RESET;
            r_cnt       <= '0;
            r_cmp       <= CNT_ONES;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_freq      <= n_freq;
            r_cnt       <= n_cnt;
            r_cmp       <= n_cmp;
            r_armed     <= n_armed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_p       <= n_p;
        r_a       <= n_a;
        r_b       <= n_b;
        r_d       <= n_d;
        r_rem     <= n_rem;
        r_step    <= n_step;
        r_now     <= n_now;
        r_due     <= n_due;
        r_o_now   <= n_o_now;
        r_o_irq   <= n_o_irq;
        r_o_due   <= n_o_due;
        r_o_armed <= n_o_armed;
    end

    assign o_out_valid    = r_out_valid;
    assign o_now_ns       = r_o_now;
    assign o_irq_pending  = r_o_irq;
    assign o_callback_due = r_o_due;
    assign o_is_armed     = r_o_armed;

endmodule

`default_nettype wire

### tb/tb_oneshot_timer_ns_compare_core.sv
`timescale 1ns / 100ps

module tb_oneshot_timer_ns_compare_core;
    import osnc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PHASE_ITEMS = 94;
    localparam int unsigned N_PHASES    = 8;
    localparam int unsigned N_DIRECTED  = 24;
    localparam logic [63:0] NS_SEC64    = 64'(NS_PER_SEC);
    localparam logic [ADDR_W-3:0] REG_UNUSED = 1'b1;

    typedef struct packed {
        logic [NS_W-1:0] now_ns;
        logic            irq_pending;
        logic            callback_due;
        logic            is_armed;
    } t_timer_result;

    typedef struct packed {
        t_op             op;
        logic [DUR_W-1:0] dur;
        logic            fixed;
        logic [NS_W-1:0] now_ns;
        logic            irq_pending;
        logic            callback_due;
        logic            is_armed;
    } t_directed_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_operation = 2'b00;
    logic [DUR_W-1:0]     i_duration_ns = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [NS_W-1:0]      o_now_ns;
    logic                 o_irq_pending;
    logic                 o_callback_due;
    logic                 o_is_armed;

    // timer state as the block should hold it
    logic [COUNTER_WIDTH-1:0] tick_cnt = '0;
    logic [COUNTER_WIDTH-1:0] cmp_val  = CNT_ONES;
    logic                     armed    = 1'b0;
    logic [FREQ_W-1:0]        tick_freq = FREQ_RESET;

    t_timer_result timer_outcomes [$];
    t_timer_result got, want;
    t_directed_row directed_rows [N_DIRECTED];

    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_reqs = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned phase_items = 0;
    int unsigned err_cnt = 0;
    int unsigned cyc_cnt = 0;

    oneshot_timer_ns_compare_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_duration_ns  (i_duration_ns),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_now_ns       (o_now_ns),
        .o_irq_pending  (o_irq_pending),
        .o_callback_due (o_callback_due),
        .o_is_armed     (o_is_armed)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [63:0] freq_eff();
        return (tick_freq == '0) ? 64'd1 : 64'(tick_freq);
    endfunction

    function automatic t_timer_result timer_predict(t_op op, logic [DUR_W-1:0] dur);
        t_timer_result r;
        logic [127:0]  prod;
        logic [63:0]   f;
        logic [63:0]   secs;
        logic [63:0]   rem;
        r = '0;
        f = freq_eff();
        case (op)
            OP_TICK: begin
                tick_cnt = tick_cnt + 64'd1;
            end
            OP_ARM: begin
                if (dur == '0) begin
                    cmp_val = CNT_ONES;
                    armed   = 1'b0;
                end else begin
                    // full 94-bit product, no wrap before the divide
                    prod    = 128'(dur) * 128'(f);
                    cmp_val = tick_cnt + 64'(prod / 128'(NS_SEC64));
                    armed   = 1'b1;
                end
            end
            OP_READ: begin
                secs     = tick_cnt / f;
                rem      = tick_cnt % f;
                r.now_ns = secs * NS_SEC64 + (rem * NS_SEC64) / f;
            end
            default: begin
                cmp_val        = CNT_ONES;
                r.callback_due = armed;
                armed          = 1'b0;
            end
        endcase
        r.irq_pending = (tick_cnt >= cmp_val);
        r.is_armed    = armed;
        return r;
    endfunction

    function automatic logic [63:0] span_for_ticks(int unsigned k);
        return (64'(k) * NS_SEC64) / freq_eff() + 64'($urandom_range(0, 3));
    endfunction

    function automatic logic [63:0] rand_span();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return {$urandom, $urandom};
            2: return '1;
            3: return 64'($urandom_range(1, 5000));
            4: return span_for_ticks($urandom_range(0, 6));
            default: return {32'd0, $urandom};
        endcase
    endfunction

    task automatic set_idling(int unsigned mode);
        case (mode)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 55; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 55; end
            default: begin src_idle_pct = 14; sink_stall_pct = 14; end
        endcase
    endtask

    task automatic send_item(input t_op op, input logic [DUR_W-1:0] dur,
                             input bit fixed = 1'b0, input t_timer_result fixed_res = '0);
        t_timer_result r;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_duration_ns <= dur;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = timer_predict(op, dur);
        timer_outcomes.push_back(fixed ? fixed_res : r);
        phase_items++;
    endtask

    task automatic send_random();
        t_op op;
        op = t_op'($urandom_range(0, 3));
        send_item(op, (op == OP_ARM) ? rand_span() : {$urandom, $urandom});
    endtask

    // arm, let it run towards expiry, then acknowledge or disarm
    task automatic run_episode();
        int unsigned k;
        int unsigned n;
        k = $urandom_range(0, 5);
        n = $urandom_range(0, k + 2);
        send_item(OP_ARM, span_for_ticks(k));
        repeat (n) begin
            if ($urandom_range(0, 3) == 0)
                send_item(OP_READ, {$urandom, $urandom});
            else
                send_item(OP_TICK, {$urandom, $urandom});
        end
        if ($urandom_range(0, 4) != 0)
            send_item(OP_ACK, {$urandom, $urandom});
        else
            send_item(OP_ARM, 64'd0);
    endtask

    task automatic wait_drained();
        while (timer_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-3:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TICK_FREQ)
            tick_freq = data[FREQ_W-1:0];
    endtask

    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (timer_outcomes.size() == 0) begin
                $error("result with no transaction outstanding");
                err_cnt++;
            end else begin
                want = timer_outcomes.pop_front();
                got.now_ns       = o_now_ns;
                got.irq_pending  = o_irq_pending;
                got.callback_due = o_callback_due;
                got.is_armed     = o_is_armed;
                if (got.now_ns !== want.now_ns) begin
                    $error("now_ns: expected %0d, got %0d", want.now_ns, got.now_ns);
                    err_cnt++;
                end
                if (got.irq_pending !== want.irq_pending) begin
                    $error("irq_pending: expected %0b, got %0b",
                           want.irq_pending, got.irq_pending);
                    err_cnt++;
                end
                if (got.callback_due !== want.callback_due) begin
                    $error("callback_due: expected %0b, got %0b",
                           want.callback_due, got.callback_due);
                    err_cnt++;
                end
                if (got.is_armed !== want.is_armed) begin
                    $error("is_armed: expected %0b, got %0b", want.is_armed, got.is_armed);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        t_timer_result fixed_res;
        logic [DATA_W-1:0] freq_cfg [N_PHASES];

        // 10 MHz after reset: one tick is 100 ns
        directed_rows = '{
            '{OP_READ, 64'd0,   1'b1, 64'd0,   1'b0, 1'b0, 1'b0},
            '{OP_ACK,  64'd0,   1'b1, 64'd0,   1'b0, 1'b0, 1'b0},
            '{OP_ARM,  64'd0,   1'b1, 64'd0,   1'b0, 1'b0, 1'b0},
            '{OP_ARM,  64'd100, 1'b1, 64'd0,   1'b0, 1'b0, 1'b1},
            '{OP_TICK, 64'd0,   1'b1, 64'd0,   1'b1, 1'b0, 1'b1},
            '{OP_READ, 64'd0,   1'b1, 64'd100, 1'b1, 1'b0, 1'b1},
            '{OP_ACK,  64'd0,   1'b1, 64'd0,   1'b0, 1'b1, 1'b0},
            '{OP_ARM,  64'd50,  1'b1, 64'd0,   1'b1, 1'b0, 1'b1},
            '{OP_ACK,  64'd0,   1'b1, 64'd0,   1'b0, 1'b1, 1'b0},
            '{OP_ARM,  '1,      1'b0, 64'd0,   1'b0, 1'b0, 1'b0},
            '{OP_TICK, 64'd0,   1'b0, 64'd0,   1'b0, 1'b0, 1'b0},
            '{OP_READ, 64'd0,   1'b0, 64'd0,   1'b0, 1'b0, 1'b0},
            '{OP_ARM,  64'd0,   1'b1, 64'd0,   1'b0, 1'b0, 1'b0},
            '{OP_ACK,  64'd0,   1'b1, 64'd0,   1'b0, 1'b0, 1'b0},
            '{OP_ARM,  64'h8000_0000_0000_0000, 1'b0, 64'd0, 1'b0, 1'b0, 1'b0},
            '{OP_ARM,  64'd1,   1'b1, 64'd0,   1'b1, 1'b0, 1'b1},
            '{OP_TICK, 64'd0,   1'b1, 64'd0,   1'b1, 1'b0, 1'b1},
            '{OP_READ, 64'd0,   1'b1, 64'd300, 1'b1, 1'b0, 1'b1},
            '{OP_ARM,  64'd250, 1'b1, 64'd0,   1'b0, 1'b0, 1'b1},
            '{OP_TICK, 64'd0,   1'b1, 64'd0,   1'b0, 1'b0, 1'b1},
            '{OP_TICK, 64'd0,   1'b1, 64'd0,   1'b1, 1'b0, 1'b1},
            '{OP_ACK,  64'd0,   1'b1, 64'd0,   1'b0, 1'b1, 1'b0},
            '{OP_TICK, '1,      1'b1, 64'd0,   1'b0, 1'b0, 1'b0},
            '{OP_READ, '1,      1'b1, 64'd600, 1'b0, 1'b0, 1'b0}
        };
        freq_cfg = '{32'd1, 32'd1000000000, 32'd0, 32'hFFFF_FFFF,
                     32'($urandom_range(1, 1000000000)), 32'd10000000,
                     $urandom, 32'd32768};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0);
        foreach (directed_rows[i]) begin
            fixed_res.now_ns       = directed_rows[i].now_ns;
            fixed_res.irq_pending  = directed_rows[i].irq_pending;
            fixed_res.callback_due = directed_rows[i].callback_due;
            fixed_res.is_armed     = directed_rows[i].is_armed;
            send_item(directed_rows[i].op, directed_rows[i].dur,
                      directed_rows[i].fixed, fixed_res);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            i_in_valid <= 1'b0;
            wait_drained();
            repeat (8) @(posedge i_clk);
            if (p == 3)
                apb_write(REG_UNUSED, $urandom);
            apb_write(REG_TICK_FREQ, freq_cfg[p]);
            set_idling(p % 4);
            phase_items = 0;
            if (p == 5) begin
                // long output hold-off with the input kept busy
                src_idle_pct = 0;
                hold_reqs++;
                repeat (12) send_random();
                i_in_valid <= 1'b0;
                wait_drained();
                set_idling(p % 4);
            end
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 7)
                    run_episode();
                else
                    send_random();
            end
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (err_cnt == 0 && timer_outcomes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
sv/osnc_pkg.sv
sv/oneshot_timer_ns_compare_core.sv
tb/tb_oneshot_timer_ns_compare_core.sv
